### rtl/vku_pkg.sv
// ----------------------------------------------------------------------------
// vku_pkg
// Shared operation codes and control types of the kinematics update block.
// ----------------------------------------------------------------------------
package vku_pkg;

  // Operations of the shared bit-serial arithmetic unit
  typedef logic [1:0] vku_op_t;

  localparam vku_op_t OP_MUL  = 2'd0;
  localparam vku_op_t OP_DIV  = 2'd1;
  localparam vku_op_t OP_SQRT = 2'd2;

  // Control from the sequencer to the arithmetic unit
  typedef struct packed {
    logic    start;
    vku_op_t op;
  } vku_ctl_t;

endpackage

### rtl/vku_serial_unit.sv
// ----------------------------------------------------------------------------
// vku_serial_unit
// Bit-serial multiply, restoring divide and integer square root, one result
// bit per cycle, shared by all steps of the kinematics update.
// ----------------------------------------------------------------------------
module vku_serial_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  vku_pkg::vku_ctl_t        ctl,
  input  logic [2*WORD_BITS-1:0]   opa,   // multiplicand, dividend or radicand
  input  logic [WORD_BITS-1:0]     opb,   // multiplier or divisor
  output logic                     done,
  output logic [2*WORD_BITS-1:0]   res
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(2 * W + 1);

  logic                busy;
  vku_pkg::vku_op_t    op;
  logic [CW-1:0]       cnt;
  logic [2*W-1:0]      acc;
  logic [W+1:0]        rem;
  logic [W-1:0]        root;
  logic [W-1:0]        mcand;
  logic [W-1:0]        divisor;

  logic [W:0]          mul_sum;
  logic [W:0]          div_sh;
  logic                div_ge;
  logic [W:0]          div_rem;
  logic [W+1:0]        sq_sh;
  logic [W+1:0]        sq_trial;
  logic                sq_ge;
  logic [W+1:0]        sq_rem;

  // One step of each operation
  always_comb begin
    mul_sum  = {1'b0, acc[2*W-1:W]} + (acc[0] ? {1'b0, mcand} : {(W+1){1'b0}});
    div_sh   = {rem[W-1:0], acc[2*W-1]};
    div_ge   = (div_sh >= {1'b0, divisor});
    div_rem  = div_ge ? (div_sh - {1'b0, divisor}) : div_sh;
    sq_sh    = {rem[W-1:0], acc[2*W-1:2*W-2]};
    sq_trial = {root, 2'b01};
    sq_ge    = (sq_sh >= sq_trial);
    sq_rem   = sq_ge ? (sq_sh - sq_trial) : sq_sh;
  end

  // Control: busy flag, step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= vku_pkg::OP_MUL;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (ctl.start && !busy) begin
        busy <= 1'b1;
        op   <= ctl.op;
        cnt  <= (ctl.op == vku_pkg::OP_DIV) ? CW'(2 * W) : CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (ctl.start && !busy) begin
      acc     <= (ctl.op == vku_pkg::OP_MUL) ? {{W{1'b0}}, opb} : opa;
      mcand   <= opa[W-1:0];
      divisor <= opb;
      rem     <= '0;
      root    <= '0;
    end else if (busy) begin
      case (op)
        vku_pkg::OP_MUL: begin
          acc <= {mul_sum, acc[W-1:1]};
        end
        vku_pkg::OP_DIV: begin
          acc <= {acc[2*W-2:0], div_ge};
          rem <= {1'b0, div_rem};
        end
        vku_pkg::OP_SQRT: begin
          acc  <= {acc[2*W-3:0], 2'b00};
          rem  <= sq_rem;
          root <= {root[W-2:0], sq_ge};
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  assign res = (op == vku_pkg::OP_SQRT) ? {{W{1'b0}}, root} : acc;

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("unit completion without a running operation");

  a_no_restart : assert property (@(posedge clk) disable iff (rst)
    (busy && cnt != CW'(1)) |=> busy) else $error("unit stopped before its last step");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0)) else $error("unit running with an empty step count");

endmodule

### rtl/vehicle_kinematics_update_top.sv
// ----------------------------------------------------------------------------
// vehicle_kinematics_update_top
// One Euler step of a steered 2D vehicle per input transfer, in fixed point.
// ----------------------------------------------------------------------------
// Each input transfer carries a steering force and a time step; the block
// divides the force by the mass, integrates velocity, clamps the speed to
// max_speed, integrates position and renews the unit heading, then offers one
// output transfer. All work goes through one bit-serial unit that produces one
// bit per cycle, one operation at a time. The speed clamp runs only when the
// speed exceeds max_speed, and the heading update only when the squared speed
// exceeds a small threshold. A new item is taken as soon as the previous one
// has been placed in the output register, even while that result still waits
// to be taken.
// ----------------------------------------------------------------------------
module vehicle_kinematics_update_top #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  // Fields from bit 0 up: force_x, force_y, time_step, zero padding
  input  logic [((2*WORD_BITS+FRAC_BITS+1+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // Fields from bit 0 up: pos_x, pos_y, vel_x, vel_y, heading_x, heading_y,
  // side_x, side_y, zero padding
  output logic [((4*WORD_BITS+4*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  input  logic                                             cfg_we,
  input  logic                                             cfg_index,
  input  logic [WORD_BITS-2:0]                             cfg_data
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int HB  = FRAC_BITS + 2;
  localparam int OW  = ((4*WORD_BITS+4*(FRAC_BITS+2)+7)/8)*8;
  localparam int OPAD = OW - 4 * W - 4 * HB;

  localparam logic [2*W-1:0] CAP_W = (2*W)'(1) << W;
  localparam logic [2*W-1:0] ONE_W = (2*W)'(1) << F;
  localparam logic [2*W-1:0] EPS_Q =
    (2*W)'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000000);
  localparam logic [F:0]     ONE_DT = (F+1)'(1) << F;
  localparam logic [W-1:0]   S_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   S_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [HB-1:0]  ONE_H = HB'(1) << F;

  // Sequencer steps
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_AX   = 5'd1;
  localparam logic [4:0] ST_AY   = 5'd2;
  localparam logic [4:0] ST_VX   = 5'd3;
  localparam logic [4:0] ST_VY   = 5'd4;
  localparam logic [4:0] ST_SQX  = 5'd5;
  localparam logic [4:0] ST_SQY  = 5'd6;
  localparam logic [4:0] ST_MSQ  = 5'd7;
  localparam logic [4:0] ST_CLEN = 5'd8;
  localparam logic [4:0] ST_CMX  = 5'd9;
  localparam logic [4:0] ST_CDX  = 5'd10;
  localparam logic [4:0] ST_CMY  = 5'd11;
  localparam logic [4:0] ST_CDY  = 5'd12;
  localparam logic [4:0] ST_PX   = 5'd13;
  localparam logic [4:0] ST_PY   = 5'd14;
  localparam logic [4:0] ST_HSQX = 5'd15;
  localparam logic [4:0] ST_HSQY = 5'd16;
  localparam logic [4:0] ST_HLEN = 5'd17;
  localparam logic [4:0] ST_HDX  = 5'd18;
  localparam logic [4:0] ST_HDY  = 5'd19;
  localparam logic [4:0] ST_DONE = 5'd20;

  localparam logic CFG_MASS      = 1'b0;
  localparam logic CFG_MAX_SPEED = 1'b1;

  // Magnitude of a signed word
  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  // Apply a sign to a capped magnitude and saturate to the signed word
  function automatic logic [W-1:0] signed_of(input logic neg, input logic [2*W-1:0] q);
    logic big;
    big = (q >= ((2*W)'(1) << (W - 1)));
    if (neg) begin
      signed_of = big ? S_MIN : (~q[W-1:0] + W'(1));
    end else begin
      signed_of = big ? S_MAX : q[W-1:0];
    end
  endfunction

  // Drop the fraction bits of a product, capped at 2^W
  function automatic logic [2*W-1:0] shr_cap(input logic [2*W-1:0] p);
    logic [2*W-1:0] v;
    v = p >> F;
    shr_cap = (v > CAP_W) ? CAP_W : v;
  endfunction

  // Saturating signed add of two words
  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      sat_add = s[W] ? S_MIN : S_MAX;
    end else begin
      sat_add = s[W-1:0];
    end
  endfunction

  // Configuration and vehicle state
  logic [W-2:0]   mass;
  logic [W-2:0]   max_speed;
  logic [W-1:0]   position_x, position_y, velocity_x, velocity_y;
  logic [HB-1:0]  direction_x, direction_y;

  // Item registers and intermediate values
  logic [4:0]     state;
  logic           launched;
  logic [W-1:0]   fx, fy, ax, ay;
  logic [F:0]     dt;
  logic [2*W-1:0] sq;
  logic [2*W-1:0] tmp;
  logic [W-1:0]   len;

  // Output register
  logic [W-1:0]   o_pos_x, o_pos_y, o_vel_x, o_vel_y;
  logic [HB-1:0]  o_hx, o_hy, o_sx, o_sy;

  vku_pkg::vku_ctl_t ctl;
  logic [2*W-1:0]    opa;
  logic [W-1:0]      opb;
  logic              u_done;
  logic [2*W-1:0]    u_res;
  logic [2*W-1:0]    sq_sum;
  logic [2*W-1:0]    q_cap;
  logic [2*W-1:0]    h_cap;
  logic [W-1:0]      mass_eff;
  logic [F:0]        dt_in;
  logic              load_out;

  vku_serial_unit #(.WORD_BITS(W)) u_unit (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .opa  (opa),
    .opb  (opb),
    .done (u_done),
    .res  (u_res)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign mass_eff = (mass == '0) ? W'(1) : {1'b0, mass};
  assign dt_in    = s_axis_tdata[2*W+F:2*W];
  assign sq_sum   = sq + u_res;
  assign q_cap    = (u_res > CAP_W) ? CAP_W : u_res;
  assign h_cap    = (u_res > ONE_W) ? ONE_W : u_res;
  assign load_out = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Operand selection for the shared unit
  always_comb begin
    ctl.start = (state != ST_IDLE) && (state != ST_DONE) && !launched;
    ctl.op    = vku_pkg::OP_MUL;
    opa       = '0;
    opb       = '0;
    case (state)
      ST_AX: begin
        ctl.op = vku_pkg::OP_DIV;
        opa    = (2*W)'(mag(fx)) << F;
        opb    = mass_eff;
      end
      ST_AY: begin
        ctl.op = vku_pkg::OP_DIV;
        opa    = (2*W)'(mag(fy)) << F;
        opb    = mass_eff;
      end
      ST_VX: begin
        opa = (2*W)'(mag(ax));
        opb = W'(dt);
      end
      ST_VY: begin
        opa = (2*W)'(mag(ay));
        opb = W'(dt);
      end
      ST_SQX, ST_HSQX: begin
        opa = (2*W)'(mag(velocity_x));
        opb = mag(velocity_x);
      end
      ST_SQY, ST_HSQY: begin
        opa = (2*W)'(mag(velocity_y));
        opb = mag(velocity_y);
      end
      ST_MSQ: begin
        opa = (2*W)'(max_speed);
        opb = {1'b0, max_speed};
      end
      ST_CLEN, ST_HLEN: begin
        ctl.op = vku_pkg::OP_SQRT;
        opa    = sq;
      end
      ST_CMX: begin
        opa = (2*W)'(mag(velocity_x));
        opb = {1'b0, max_speed};
      end
      ST_CMY: begin
        opa = (2*W)'(mag(velocity_y));
        opb = {1'b0, max_speed};
      end
      ST_CDX, ST_CDY: begin
        ctl.op = vku_pkg::OP_DIV;
        opa    = tmp;
        opb    = len;
      end
      ST_PX: begin
        opa = (2*W)'(mag(velocity_x));
        opb = W'(dt);
      end
      ST_PY: begin
        opa = (2*W)'(mag(velocity_y));
        opb = W'(dt);
      end
      ST_HDX: begin
        ctl.op = vku_pkg::OP_DIV;
        opa    = (2*W)'(mag(velocity_x)) << F;
        opb    = len;
      end
      ST_HDY: begin
        ctl.op = vku_pkg::OP_DIV;
        opa    = (2*W)'(mag(velocity_y)) << F;
        opb    = len;
      end
      default: begin
        ctl.op = vku_pkg::OP_MUL;
      end
    endcase
  end

  // Sequencer, configuration and vehicle state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      launched      <= 1'b0;
      mass          <= (W-1)'(ONE_W);
      max_speed     <= (W-1)'(ONE_W);
      position_x    <= '0;
      position_y    <= '0;
      velocity_x    <= '0;
      velocity_y    <= '0;
      direction_x   <= ONE_H;
      direction_y   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MASS:      mass      <= cfg_data;
          CFG_MAX_SPEED: max_speed <= cfg_data;
          default:       mass      <= mass;
        endcase
      end

      if (ctl.start) begin
        launched <= 1'b1;
      end
      if (u_done) begin
        launched <= 1'b0;
      end

      // A new result replaces one that is taken in the same cycle
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_AX;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          if (u_done) begin
            case (state)
              ST_AX:   state <= ST_AY;
              ST_AY:   state <= ST_VX;
              ST_VX: begin
                velocity_x <= sat_add(velocity_x, signed_of(ax[W-1], shr_cap(u_res)));
                state      <= ST_VY;
              end
              ST_VY: begin
                velocity_y <= sat_add(velocity_y, signed_of(ay[W-1], shr_cap(u_res)));
                state      <= ST_SQX;
              end
              ST_SQX:  state <= ST_SQY;
              ST_SQY:  state <= ST_MSQ;
              ST_MSQ:  state <= (sq > u_res) ? ST_CLEN : ST_PX;
              ST_CLEN: state <= ST_CMX;
              ST_CMX:  state <= ST_CDX;
              ST_CDX: begin
                velocity_x <= signed_of(velocity_x[W-1], q_cap);
                state      <= ST_CMY;
              end
              ST_CMY:  state <= ST_CDY;
              ST_CDY: begin
                velocity_y <= signed_of(velocity_y[W-1], q_cap);
                state      <= ST_PX;
              end
              ST_PX: begin
                position_x <= sat_add(position_x, signed_of(velocity_x[W-1], shr_cap(u_res)));
                state      <= ST_PY;
              end
              ST_PY: begin
                position_y <= sat_add(position_y, signed_of(velocity_y[W-1], shr_cap(u_res)));
                state      <= ST_HSQX;
              end
              ST_HSQX: state <= ST_HSQY;
              ST_HSQY: state <= (sq_sum > EPS_Q) ? ST_HLEN : ST_DONE;
              ST_HLEN: state <= ST_HDX;
              ST_HDX: begin
                direction_x <= velocity_x[W-1] ? (~h_cap[HB-1:0] + HB'(1)) : h_cap[HB-1:0];
                state       <= ST_HDY;
              end
              ST_HDY: begin
                direction_y <= velocity_y[W-1] ? (~h_cap[HB-1:0] + HB'(1)) : h_cap[HB-1:0];
                state       <= ST_DONE;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  // Item payload and intermediate registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      fx <= s_axis_tdata[W-1:0];
      fy <= s_axis_tdata[2*W-1:W];
      dt <= (dt_in > ONE_DT) ? ONE_DT : dt_in;
    end
    if (u_done) begin
      case (state)
        ST_AX:            ax  <= signed_of(fx[W-1], q_cap);
        ST_AY:            ay  <= signed_of(fy[W-1], q_cap);
        ST_SQX, ST_HSQX:  sq  <= u_res;
        ST_SQY, ST_HSQY:  sq  <= sq_sum;
        ST_CLEN, ST_HLEN: len <= u_res[W-1:0];
        ST_CMX, ST_CMY:   tmp <= u_res;
        default:          tmp <= tmp;
      endcase
    end
    if (load_out) begin
      o_pos_x <= position_x;
      o_pos_y <= position_y;
      o_vel_x <= velocity_x;
      o_vel_y <= velocity_y;
      o_hx    <= direction_x;
      o_hy    <= direction_y;
      o_sx    <= ~direction_y + HB'(1);
      o_sy    <= direction_x;
    end
  end

  assign m_axis_tdata = {{OPAD{1'b0}}, o_sy, o_sx, o_hy, o_hx,
                         o_vel_y, o_vel_x, o_pos_y, o_pos_x};

  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_AX))
    else $error("accepted item did not start the update");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  a_unit_launched : assert property (@(posedge clk) disable iff (rst)
    u_done |-> launched) else $error("unit result without a launched operation");

  a_heading_unit : assert property (@(posedge clk) disable iff (rst)
    ($signed(direction_x) <= $signed(ONE_H)) && ($signed(direction_x) >= -$signed(ONE_H)))
    else $error("heading component beyond one");

endmodule
